>>> rtl/core/qts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_pkg
// Types and constants shared by the quoted token splitter modules.
// ----------------------------------------------------------------------------
package qts_pkg;

	localparam int POS_W       = 12;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_EQUALS = 8'h3D;

	typedef enum logic [2:0] {
		MODE_SKIP     = 3'd0,
		MODE_PLAIN    = 3'd1,
		MODE_QUOTED   = 3'd2,
		MODE_SEEK_SEP = 3'd3,
		MODE_DISCARD  = 3'd4
	} scan_mode_t;

	typedef enum logic [1:0] {
		KIND_TOKEN  = 2'd0,
		KIND_ACCEPT = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		SEP_EOL    = 2'd0,
		SEP_COMMA  = 2'd1,
		SEP_EQUALS = 2'd2,
		SEP_BLANK  = 2'd3
	} sep_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       buf_end;
	} text_item_t;

	typedef struct packed {
		kind_t            kind;
		logic [POS_W-1:0] tok_start;
		logic [POS_W-1:0] tok_len;
		sep_t             sep;
		logic             last;
	} result_item_t;

	// Work for one byte: an optional token, then an optional verdict
	typedef struct packed {
		logic             tok_vld;
		logic [POS_W-1:0] tok_start;
		logic [POS_W-1:0] tok_len;
		sep_t             sep;
		logic             vrd_vld;
		kind_t            vrd_kind;
	} split_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

>>> rtl/core/qts_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_stream_if
// Valid/ready channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface qts_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/quoted_token_splitter.sv
`timescale 1ns / 1ps
// A byte's results pass through the job queue and then the output register.
// Throughput: one byte per cycle while the queue is not full; a byte with two
// results sends them in turn, and a four-entry job queue absorbs the difference.
// Reset: asynchronous, returns to whitespace skipping at line position zero
// with the queue and output register empty.
// ----------------------------------------------------------------------------
// quoted_token_splitter
// Splits a byte stream line into tokens with positions, lengths and
// separators, followed by an accept or reject verdict.
// ----------------------------------------------------------------------------
module quoted_token_splitter #(
	parameter int MAX_LINE = 2048
) (
	input logic          clk,
	input logic          arst_n,
	qts_stream_if.sink   text,
	qts_stream_if.source result
);

	qts_pkg::split_job_t  push_job;
	qts_pkg::split_job_t  head_job;
	qts_pkg::queue_stat_t stat;
	logic                 push;
	logic                 pop;

	qts_front #(
		.MAX_LINE (MAX_LINE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.stat     (stat),
		.push     (push),
		.push_job (push_job)
	);

	qts_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.stat     (stat)
	);

	qts_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_job (head_job),
		.stat     (stat),
		.pop      (pop),
		.result   (result)
	);

endmodule

>>> rtl/core/qts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_front
// Accepts line bytes, tracks the scan mode and positions, and queues the
// token and verdict results each byte causes.
// ----------------------------------------------------------------------------
module qts_front #(
	parameter int MAX_LINE = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	qts_stream_if.sink           text,
	input  qts_pkg::queue_stat_t stat,
	output logic                 push,
	output qts_pkg::split_job_t  push_job
);

	localparam int PW = $clog2(MAX_LINE + 1);

	qts_pkg::scan_mode_t mode_q, mode_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [PW-1:0] begin_q, begin_d;
	logic [PW-1:0] finish_q, finish_d;

	logic          accept;
	logic          closing;
	logic          blank;
	logic          sepc;
	logic          quote;
	logic [PW-1:0] pos_inc;
	logic [PW-1:0] plain_diff;
	logic [PW-1:0] held_diff;
	qts_pkg::sep_t ch_sep;

	assign text.ready = !stat.full;
	assign accept     = text.valid && text.ready;

	assign closing = text.data.buf_end
		|| (text.data.ch == qts_pkg::CH_NUL)
		|| (text.data.ch == qts_pkg::CH_LF)
		|| (pos_q >= PW'(MAX_LINE));
	assign blank = text.data.ch inside {qts_pkg::CH_TAB, qts_pkg::CH_VT, qts_pkg::CH_FF,
		qts_pkg::CH_CR, qts_pkg::CH_SPACE};
	assign sepc  = (text.data.ch == qts_pkg::CH_COMMA) || (text.data.ch == qts_pkg::CH_EQUALS);
	assign quote = (text.data.ch == qts_pkg::CH_QUOTE);
	assign ch_sep = (text.data.ch == qts_pkg::CH_COMMA) ? qts_pkg::SEP_COMMA
		: qts_pkg::SEP_EQUALS;

	assign pos_inc    = pos_q + PW'(1);
	assign plain_diff = pos_q - begin_q;
	assign held_diff  = finish_q - begin_q;

	// Next state
	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		begin_d  = begin_q;
		finish_d = finish_q;
		if (accept) begin
			if (closing) begin
				mode_d   = qts_pkg::MODE_SKIP;
				pos_d    = '0;
				begin_d  = '0;
				finish_d = '0;
			end else begin
				pos_d = pos_inc;
				case (mode_q)
					qts_pkg::MODE_SKIP: begin
						if (blank) begin
							mode_d = qts_pkg::MODE_SKIP;
						end else if (sepc) begin
							mode_d = qts_pkg::MODE_DISCARD;
						end else if (quote) begin
							begin_d = pos_inc;
							mode_d  = qts_pkg::MODE_QUOTED;
						end else begin
							begin_d = pos_q;
							mode_d  = qts_pkg::MODE_PLAIN;
						end
					end
					qts_pkg::MODE_PLAIN: begin
						if (quote) begin
							mode_d = qts_pkg::MODE_DISCARD;
						end else if (sepc) begin
							mode_d = qts_pkg::MODE_SKIP;
						end else if (blank) begin
							finish_d = pos_q;
							mode_d   = qts_pkg::MODE_SEEK_SEP;
						end
					end
					qts_pkg::MODE_QUOTED: begin
						if (quote) begin
							finish_d = pos_q;
							mode_d   = qts_pkg::MODE_SEEK_SEP;
						end
					end
					qts_pkg::MODE_SEEK_SEP: begin
						if (sepc) begin
							mode_d = qts_pkg::MODE_SKIP;
						end else if (!blank) begin
							begin_d = pos_q;
							mode_d  = qts_pkg::MODE_PLAIN;
						end
					end
					default: begin
						mode_d = qts_pkg::MODE_DISCARD;
					end
				endcase
			end
		end
	end

	// Results caused by the byte
	always_comb begin
		push_job           = '0;
		push_job.tok_start = qts_pkg::POS_W'(begin_q);
		push_job.tok_len   = qts_pkg::POS_W'(plain_diff);
		push_job.sep       = qts_pkg::SEP_EOL;
		push_job.vrd_kind  = qts_pkg::KIND_ACCEPT;
		if (closing) begin
			case (mode_q)
				qts_pkg::MODE_SKIP: begin
					push_job.vrd_vld = 1'b1;
				end
				qts_pkg::MODE_PLAIN: begin
					push_job.tok_vld = 1'b1;
					push_job.vrd_vld = 1'b1;
				end
				qts_pkg::MODE_SEEK_SEP: begin
					push_job.tok_vld = 1'b1;
					push_job.tok_len = qts_pkg::POS_W'(held_diff);
					push_job.vrd_vld = 1'b1;
				end
				qts_pkg::MODE_QUOTED: begin
					push_job.vrd_vld  = 1'b1;
					push_job.vrd_kind = qts_pkg::KIND_REJECT;
				end
				default: begin
					push_job.vrd_vld = 1'b0;
				end
			endcase
		end else begin
			case (mode_q)
				qts_pkg::MODE_SKIP: begin
					if (sepc && !blank) begin
						push_job.vrd_vld  = 1'b1;
						push_job.vrd_kind = qts_pkg::KIND_REJECT;
					end
				end
				qts_pkg::MODE_PLAIN: begin
					if (quote) begin
						push_job.vrd_vld  = 1'b1;
						push_job.vrd_kind = qts_pkg::KIND_REJECT;
					end else if (sepc) begin
						push_job.tok_vld = 1'b1;
						push_job.sep     = ch_sep;
					end
				end
				qts_pkg::MODE_SEEK_SEP: begin
					push_job.tok_len = qts_pkg::POS_W'(held_diff);
					if (sepc) begin
						push_job.tok_vld = 1'b1;
						push_job.sep     = ch_sep;
					end else if (!blank) begin
						push_job.tok_vld = 1'b1;
						push_job.sep     = qts_pkg::SEP_BLANK;
					end
				end
				default: begin
					push_job.tok_vld = 1'b0;
				end
			endcase
		end
	end

	assign push = accept && (push_job.tok_vld || push_job.vrd_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= qts_pkg::MODE_SKIP;
			pos_q    <= '0;
			begin_q  <= '0;
			finish_q <= '0;
		end else begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			begin_q  <= begin_d;
			finish_q <= finish_d;
		end
	end

endmodule

>>> rtl/core/qts_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_queue
// Short FIFO of per-byte result jobs between front and back.
// ----------------------------------------------------------------------------
module qts_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  qts_pkg::split_job_t  push_job,
	input  logic                 pop,
	output qts_pkg::split_job_t  head_job,
	output qts_pkg::queue_stat_t stat
);

	localparam int AW = $clog2(qts_pkg::QUEUE_DEPTH);

	qts_pkg::split_job_t fifo_q [qts_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;

	assign stat.full  = (count_q == (AW+1)'(qts_pkg::QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head_job   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (AW+1)'(1);
				2'b01:   count_q <= count_q - (AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/qts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_back
// Unpacks queued jobs into result items, one per cycle unless the output is
// stalled by ready, through an output register.
// ----------------------------------------------------------------------------
module qts_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qts_pkg::split_job_t  head_job,
	input  qts_pkg::queue_stat_t stat,
	output logic                 pop,
	qts_stream_if.source         result
);

	qts_pkg::result_item_t out_q;
	qts_pkg::result_item_t item;
	logic                  out_vld_q;
	logic                  phase_q;
	logic                  can_load;
	logic                  load;
	logic                  emit_tok;

	assign result.valid = out_vld_q;
	assign result.data  = out_q;

	assign can_load = !out_vld_q || result.ready;
	assign load     = can_load && !stat.empty;
	// Token part goes first unless it already went out
	assign emit_tok = head_job.tok_vld && !phase_q;

	always_comb begin
		item = '0;
		pop  = 1'b0;
		if (emit_tok) begin
			item.kind      = qts_pkg::KIND_TOKEN;
			item.tok_start = head_job.tok_start;
			item.tok_len   = head_job.tok_len;
			item.sep       = head_job.sep;
			item.last      = !head_job.vrd_vld;
			pop            = load && !head_job.vrd_vld;
		end else begin
			item.kind = head_job.vrd_kind;
			item.sep  = qts_pkg::SEP_EOL;
			item.last = 1'b1;
			pop       = load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			phase_q   <= 1'b0;
		end else begin
			if (can_load) begin
				out_vld_q <= !stat.empty;
			end
			if (load) begin
				phase_q <= emit_tok && head_job.vrd_vld;
			end
		end
	end

endmodule
